// ===== rtl/pcm_pkg.sv =====
package pcm_pkg;

  localparam int ACC_W = 40;

  // Command codes of the request field cmd
  localparam logic [1:0] CMD_WEIGHT = 2'd0;
  localparam logic [1:0] CMD_BIAS   = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_IN_CH   = 2'd0;
  localparam logic [1:0] CFG_OUT_CH  = 2'd1;
  localparam logic [1:0] CFG_BIAS_EN = 2'd2;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [3:0]          out_index;
    logic [3:0]          in_index;
    logic signed [15:0]  value;
  } pcm_in_t;

  typedef struct packed {
    logic [3:0]          out_channel;
    logic signed [15:0]  result;
    logic                last;
  } pcm_out_t;

  // Per-cell table write
  typedef struct packed {
    logic                wt_we;
    logic                bias_we;
    logic [3:0]          wt_addr;
    logic signed [15:0]  wdata;
  } pcm_wr_t;

  // Broadcast control shared by all cells
  typedef struct packed {
    logic                rd_en;
    logic [3:0]          raddr;
    logic                s1_vld;
    logic                s1_wz;
    logic signed [15:0]  s1_sample;
    logic                s2_vld;
    logic                s2_last;
    logic                s3_fin;
    logic                bias_en;
    logic                shift;
  } pcm_ctl_t;

  // Add bias in Q10.22, drop 14 fraction bits (floor), saturate to Q8.8.
  function automatic logic signed [15:0] pcm_finish(input logic signed [ACC_W-1:0] acc,
                                                    input logic signed [15:0] bias);
    logic signed [ACC_W-1:0] total;
    logic [25:0]             q;
    logic                    fits;
    total = acc + {{(ACC_W-30){bias[15]}}, bias, 14'b0};
    q     = total[ACC_W-1:14];
    fits  = (q[25:15] == {11{q[25]}});
    if (fits) begin
      pcm_finish = q[15:0];
    end else if (q[25]) begin
      pcm_finish = 16'sh8000;
    end else begin
      pcm_finish = 16'sh7fff;
    end
  endfunction

endpackage

// ===== rtl/pointwise_conv_channel_mixer_core.sv =====
// Pointwise 1x1 convolution: one row of cells, one cell per output channel.
// Weight and bias requests and non-final samples: one request per cycle unless
// in_stall is high. Final sample of a pixel: it passes s1, s2 and s3, then one
// result per cycle unless out_stall is high; input stalls until the pixel's last result leaves.
// Reset (rst_n low, synchronous) clears accumulators, the channel counter and
// pipeline control, and loads in_channels 4, out_channels 1, bias off.
module pointwise_conv_channel_mixer_core import pcm_pkg::*; #(
  parameter int MAX_IN_CHANNELS  = 16,
  parameter int MAX_OUT_CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  pcm_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output pcm_out_t    out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [4:0]  cfg_wdata
);

  // The 4-bit channel fields never reach beyond 16 rows or cells.
  localparam int ROWS  = (MAX_IN_CHANNELS  < 16) ? MAX_IN_CHANNELS  : 16;
  localparam int NCELL = (MAX_OUT_CHANNELS < 16) ? MAX_OUT_CHANNELS : 16;
  localparam logic [4:0] ROWS_C  = 5'(ROWS);
  localparam logic [4:0] NCELL_C = 5'(NCELL);

  // Configuration registers
  logic [4:0] in_ch_r;
  logic [4:0] out_ch_r;
  logic       bias_en_r;

  // Request side
  logic       in_acc;
  logic       is_smp;
  logic [4:0] ein;
  logic [4:0] eout;
  logic       pix_last;
  logic       row_ok;
  logic [3:0] chan_r;
  logic [3:0] chan_nxt;
  logic       busy_r;

  // Sample pipeline: s1 weight read, s2 product, s3 pixel sum captured
  logic               s1_vld_r;
  logic               s1_last_r;
  logic               s1_wz_r;
  logic signed [15:0] s1_sample_r;
  logic               s2_vld_r;
  logic               s2_last_r;
  logic               s3_fin_r;

  // Result drain
  logic       out_acc;
  logic [4:0] cnt_r;
  logic [3:0] idx_r;

  pcm_ctl_t           ctl;
  pcm_wr_t            wr   [NCELL];
  logic signed [15:0] res  [NCELL];

  assign in_stall = busy_r;
  assign in_acc   = in_valid && !in_stall;
  assign is_smp   = (in_data.cmd == CMD_SAMPLE);
  assign out_acc  = out_valid && !out_stall;

  // Clamp the channel counts to what the tables hold; zero acts as one.
  always_comb begin
    if (in_ch_r == 5'd0) begin
      ein = 5'd1;
    end else if (in_ch_r > ROWS_C) begin
      ein = ROWS_C;
    end else begin
      ein = in_ch_r;
    end
    if (out_ch_r == 5'd0) begin
      eout = 5'd1;
    end else if (out_ch_r > NCELL_C) begin
      eout = NCELL_C;
    end else begin
      eout = out_ch_r;
    end
  end

  // A pixel ends on the first sample whose channel reaches the count.
  assign pix_last = ({1'b0, chan_r} + 5'd1) >= ein;
  assign chan_nxt = pix_last ? 4'd0 : chan_r + 4'd1;
  // Weight writes past the table drop; a sample past it uses weight zero.
  assign row_ok   = {1'b0, in_data.in_index} < ROWS_C;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_ch_r   <= 5'd4;
      out_ch_r  <= 5'd1;
      bias_en_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IN_CH:   in_ch_r   <= cfg_wdata;
        CFG_OUT_CH:  out_ch_r  <= cfg_wdata;
        CFG_BIAS_EN: bias_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r    <= 4'd0;
      busy_r    <= 1'b0;
      s1_vld_r  <= 1'b0;
      s1_last_r <= 1'b0;
      s1_wz_r   <= 1'b0;
      s2_vld_r  <= 1'b0;
      s2_last_r <= 1'b0;
      s3_fin_r  <= 1'b0;
      cnt_r     <= 5'd0;
      idx_r     <= 4'd0;
    end else begin
      s1_vld_r  <= in_acc && is_smp;
      s1_last_r <= pix_last;
      s1_wz_r   <= {1'b0, chan_r} >= ROWS_C;
      s2_vld_r  <= s1_vld_r;
      s2_last_r <= s1_last_r;
      s3_fin_r  <= s2_vld_r && s2_last_r;

      // Advance the channel; hold input from the final sample to the last result.
      if (in_acc && is_smp) begin
        chan_r <= chan_nxt;
        if (pix_last) begin
          busy_r <= 1'b1;
        end
      end

      if (s3_fin_r) begin
        cnt_r <= eout;
        idx_r <= 4'd0;
      end else if (out_acc) begin
        cnt_r <= cnt_r - 5'd1;
        idx_r <= idx_r + 4'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_smp) begin
      s1_sample_r <= in_data.value;
    end
  end

  always_comb begin
    ctl.rd_en     = in_acc && is_smp;
    ctl.raddr     = chan_r;
    ctl.s1_vld    = s1_vld_r;
    ctl.s1_wz     = s1_wz_r;
    ctl.s1_sample = s1_sample_r;
    ctl.s2_vld    = s2_vld_r;
    ctl.s2_last   = s2_last_r;
    ctl.s3_fin    = s3_fin_r;
    ctl.bias_en   = bias_en_r;
    ctl.shift     = out_acc;
  end

  // Row of cells; results shift toward cell 0, which drives the output.
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    logic signed [15:0] nbr;

    assign wr[i].wt_we   = in_acc && (in_data.cmd == CMD_WEIGHT) &&
                           (in_data.out_index == 4'(i)) && row_ok;
    assign wr[i].bias_we = in_acc && (in_data.cmd == CMD_BIAS) &&
                           (in_data.out_index == 4'(i));
    assign wr[i].wt_addr = in_data.in_index;
    assign wr[i].wdata   = in_data.value;

    if (i == NCELL - 1) begin : g_end
      assign nbr = 16'sd0;
    end else begin : g_mid
      assign nbr = res[i+1];
    end

    pcm_cell #(
      .ROWS(ROWS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr      (wr[i]),
      .ctl     (ctl),
      .nbr_in  (nbr),
      .res_out (res[i])
    );
  end

  assign out_valid            = (cnt_r != 5'd0);
  assign out_data.out_channel = idx_r;
  assign out_data.result      = res[0];
  assign out_data.last        = (cnt_r == 5'd1);

endmodule

// ===== rtl/pcm_ram.sv =====
module pcm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== rtl/pcm_cell.sv =====
module pcm_cell import pcm_pkg::*; #(
  parameter int ROWS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pcm_wr_t            wr,
  input  pcm_ctl_t           ctl,
  input  logic signed [15:0] nbr_in,
  output logic signed [15:0] res_out
);

  localparam int AW = $clog2(ROWS);

  logic [15:0]              w_q;
  logic signed [15:0]       w_eff;
  logic signed [15:0]       sample;
  logic signed [31:0]       prod_nxt;
  logic signed [31:0]       prod_r;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  fin_r;
  logic signed [15:0]       bias_r;
  logic signed [15:0]       bias_sel;
  logic signed [15:0]       res_r;

  // Weight row of this output channel
  pcm_ram #(
    .WIDTH(16),
    .DEPTH(ROWS)
  ) u_wt (
    .clk   (clk),
    .we    (wr.wt_we),
    .waddr (wr.wt_addr[AW-1:0]),
    .wdata (wr.wdata),
    .re    (ctl.rd_en),
    .raddr (ctl.raddr[AW-1:0]),
    .rdata (w_q)
  );

  assign sample   = ctl.s1_sample;
  assign w_eff    = ctl.s1_wz ? 16'sd0 : $signed(w_q);
  assign prod_nxt = sample * w_eff;
  assign prod_ext = {{(ACC_W-32){prod_r[31]}}, prod_r};
  assign sum      = acc_r + prod_ext;
  assign bias_sel = ctl.bias_en ? bias_r : 16'sd0;
  assign res_out  = res_r;

  always_ff @(posedge clk) begin
    if (wr.bias_we) begin
      bias_r <= wr.wdata;
    end
    if (ctl.s1_vld) begin
      prod_r <= prod_nxt;
    end
    if (ctl.s2_vld && ctl.s2_last) begin
      fin_r <= sum;
    end
    if (ctl.s3_fin) begin
      res_r <= pcm_finish(fin_r, bias_sel);
    end else if (ctl.shift) begin
      res_r <= nbr_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (ctl.s2_vld) begin
      acc_r <= ctl.s2_last ? '0 : sum;
    end
  end

endmodule

// ===== bench/pointwise_conv_channel_mixer_core_tb.sv =====
module pointwise_conv_channel_mixer_core_tb import pcm_pkg::*; ();

  // Code that the block must ignore
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  // Channel counts clamp to this on both sides
  localparam int MAX_CH = 16;
  // Far above the slowest clean run: ~850 requests, up to 16 results per
  // pixel, random gaps on both sides, one long drain hold and config pauses.
  localparam int CYCLE_LIMIT = 100000;
  localparam int HOLD_CYCLES = 300;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 35;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  pcm_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  pcm_out_t out_data;
  logic     cfg_we;
  logic [1:0] cfg_index;
  logic [4:0] cfg_wdata;

  pointwise_conv_channel_mixer_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Mixer predictor: tables, accumulators, channel counter and registers
  // ---------------------------------------------------------------------------
  logic signed [15:0] wt_tbl   [MAX_CH][MAX_CH];
  logic signed [15:0] bias_tbl [MAX_CH];
  logic signed [39:0] mix_acc  [MAX_CH];
  logic [3:0]         chan_cnt   = '0;
  logic [4:0]         in_ch_cfg  = 5'd4;
  logic [4:0]         out_ch_cfg = 5'd1;
  logic               bias_on    = 1'b0;

  pcm_out_t req_results [$];   // results caused by the request just taken
  pcm_out_t pending_res [$];   // results still owed by the block, oldest first
  int       mismatch_cnt = 0;
  int       cycle_cnt    = 0;

  // Shared between the sender and the drain side; written with NBAs only
  logic quiet   = 1'b0;   // no idling on either side
  logic hold_go = 1'b0;   // start the long drain hold

  initial begin
    foreach (mix_acc[co]) mix_acc[co] = '0;
  end

  function automatic int eff_count(logic [4:0] n);
    if (n == 0) return 1;
    if (n > MAX_CH) return MAX_CH;
    return n;
  endfunction

  // Apply one request to the predictor; fill req_results with what it causes.
  function automatic void mix_step(input pcm_in_t r);
    logic signed [15:0] v;
    logic signed [39:0] bias_ext;
    logic signed [39:0] total;
    logic signed [39:0] q;
    pcm_out_t           res;
    int                 n_out;
    int                 co;
    v = r.value;
    req_results.delete();
    case (r.cmd)
      CMD_WEIGHT: wt_tbl[r.out_index][r.in_index] = v;
      CMD_BIAS:   bias_tbl[r.out_index] = v;
      CMD_SAMPLE: begin
        // Q8.8 sample times Q2.14 weight lands in Q10.22, summed exactly
        for (co = 0; co < MAX_CH; co++) begin
          mix_acc[co] = mix_acc[co] + v * wt_tbl[co][chan_cnt];
        end
        if (int'(chan_cnt) + 1 < eff_count(in_ch_cfg)) begin
          chan_cnt = chan_cnt + 4'd1;
        end else begin
          n_out = eff_count(out_ch_cfg);
          for (co = 0; co < n_out; co++) begin
            total = mix_acc[co];
            if (bias_on) begin
              bias_ext = bias_tbl[co];
              total    = total + (bias_ext <<< 14);
            end
            // Floor to Q8.8, then clip
            q = total >>> 14;
            if (q > 40'sd32767) begin
              res.result = 16'sh7fff;
            end else if (q < -40'sd32768) begin
              res.result = 16'sh8000;
            end else begin
              res.result = q[15:0];
            end
            res.out_channel = 4'(co);
            res.last        = (co == n_out - 1);
            req_results.push_back(res);
          end
          for (co = 0; co < MAX_CH; co++) mix_acc[co] = '0;
          chan_cnt = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    pcm_in_t    req;
    logic [1:0] reg_idx;
    logic [4:0] reg_val;
    bit         typed;      // want holds the single expected result
    pcm_out_t   want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic pcm_in_t mk_req(logic [1:0] cmd, int oi, int ii, logic [15:0] v);
    pcm_in_t r;
    r.cmd       = cmd;
    r.out_index = 4'(oi);
    r.in_index  = 4'(ii);
    r.value     = v;
    return r;
  endfunction

  function automatic void row_req(logic [1:0] cmd, int oi, int ii, logic [15:0] v);
    dir_row_t row;
    row.kind  = ROW_REQ;
    row.req   = mk_req(cmd, oi, ii, v);
    row.typed = 1'b0;
    row.want  = '0;
    dir_rows.push_back(row);
  endfunction

  // Pixel-closing sample whose single result (channel 0, last) is known
  function automatic void row_chk(logic [15:0] v, int res);
    dir_row_t row;
    row.kind             = ROW_REQ;
    row.req              = mk_req(CMD_SAMPLE, 0, 0, v);
    row.typed            = 1'b1;
    row.want.out_channel = 4'd0;
    row.want.result      = 16'(res);
    row.want.last        = 1'b1;
    dir_rows.push_back(row);
  endfunction

  function automatic void row_cfg(logic [1:0] idx, logic [4:0] val);
    dir_row_t row;
    row.kind    = ROW_CFG;
    row.req     = '0;
    row.reg_idx = idx;
    row.reg_val = val;
    row.typed   = 1'b0;
    row.want    = '0;
    dir_rows.push_back(row);
  endfunction

  // Mostly full range, with the edges and small magnitudes well represented
  function automatic logic [15:0] rand_value();
    case ($urandom_range(7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return ($urandom_range(1)) ? 16'h0001 : 16'hffff;
      3, 4:    return 16'($urandom_range(1023)) - 16'd512;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic pcm_in_t rand_req();
    int pick;
    pick = $urandom_range(99);
    // Samples dominate so pixels complete; table writes and noise mixed in
    if (pick < 65) begin
      return mk_req(CMD_SAMPLE, $urandom_range(15), $urandom_range(15), rand_value());
    end else if (pick < 82) begin
      return mk_req(CMD_WEIGHT, $urandom_range(15), $urandom_range(15), rand_value());
    end else if (pick < 94) begin
      return mk_req(CMD_BIAS, $urandom_range(15), $urandom_range(15), rand_value());
    end
    return mk_req(CMD_UNUSED, $urandom_range(15), $urandom_range(15), rand_value());
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    mismatch_cnt++;
    $display("[%0d] MISMATCH %s: got %0d, want %0d", cycle_cnt, what, got, want);
  endtask

  // Offer one request from a falling edge; return at the falling edge after it
  // is taken, leaving in_valid for the next caller to drive.
  task automatic send_req(input pcm_in_t r, input bit typed, input pcm_out_t want);
    while (!quiet && $urandom_range(99) < 27) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    mix_step(r);
    if (typed) begin
      pending_res.push_back(want);
    end else begin
      foreach (req_results[k]) pending_res.push_back(req_results[k]);
    end
    @(negedge clk);
  endtask

  // Write one register once the block has drained; allow the pipeline to
  // finish requests that owe no result before touching the registers.
  task automatic write_reg(input logic [1:0] idx, input logic [4:0] val);
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_res.size() != 0);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IN_CH:   in_ch_cfg  = val;
      CFG_OUT_CH:  out_ch_cfg = val;
      CFG_BIAS_EN: bias_on    = val[0];
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Drain side: random stalls, one long hold so the block backs up its input
  // ---------------------------------------------------------------------------
  initial begin : drain_side
    int hold_left;
    bit hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_used) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 27);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each taken result with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_out
    pcm_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_res.size() == 0) begin
        flag_mismatch("result with none expected, channel", out_data.out_channel, -1);
      end else begin
        want = pending_res.pop_front();
        if (out_data.out_channel !== want.out_channel) begin
          flag_mismatch("out_channel", out_data.out_channel, want.out_channel);
        end
        if (out_data.result !== want.result) begin
          flag_mismatch("result", int'(out_data.result), int'(want.result));
        end
        if (out_data.last !== want.last) begin
          flag_mismatch("last", out_data.last, want.last);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    pcm_in_t    r;
    int         n;
    logic [4:0] n_in;
    logic [4:0] n_out;
    logic       b_on;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_IN_CH;
    cfg_wdata = '0;

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Fill both tables with zero so no sample ever reads an unwritten entry
    for (int oi = 0; oi < MAX_CH; oi++) begin
      for (int ii = 0; ii < MAX_CH; ii++) begin
        send_req(mk_req(CMD_WEIGHT, oi, ii, 16'h0000), 1'b0, '0);
      end
      send_req(mk_req(CMD_BIAS, oi, 0, 16'h0000), 1'b0, '0);
    end

    // Directed table. Registers are at reset values: 4 in, 1 out, no bias.
    // Zero weights give a zero pixel whatever the samples.
    row_req(CMD_SAMPLE, 0, 0, 16'h7fff);
    row_req(CMD_SAMPLE, 0, 0, 16'h8000);
    row_req(CMD_SAMPLE, 0, 0, 16'h0000);
    row_chk(16'h1234, 0);
    // One input channel: every sample closes a pixel
    row_cfg(CFG_IN_CH, 5'd1);
    row_req(CMD_WEIGHT, 0, 0, 16'h7fff);
    row_chk(16'h7fff, 32767);             // clip high
    row_chk(16'h8000, -32768);            // clip low
    row_req(CMD_WEIGHT, 0, 0, 16'h8000);
    row_chk(16'h8000, 32767);             // most negative squared clips high
    row_req(CMD_WEIGHT, 0, 0, 16'h2000);  // weight 0.5
    row_chk(16'hffff, -1);                // -0.5 floors to -1
    row_chk(16'h0003, 1);                 // 1.5 floors to 1
    // Bias on, at both extremes of the table value
    row_cfg(CFG_BIAS_EN, 5'd1);
    row_req(CMD_BIAS, 0, 0, 16'h7fff);
    row_chk(16'h0002, 32767);
    row_req(CMD_BIAS, 0, 0, 16'h8000);
    row_chk(16'hfffe, -32768);
    row_req(CMD_UNUSED, 15, 15, 16'hffff); // ignored, no result
    // Bias off: table is kept but not added
    row_cfg(CFG_BIAS_EN, 5'd0);
    row_chk(16'h0100, 128);
    // All sixteen output channels from a two-channel pixel
    row_cfg(CFG_OUT_CH, 5'd16);
    row_cfg(CFG_IN_CH, 5'd2);
    row_req(CMD_WEIGHT, 15, 1, 16'h4000);
    row_req(CMD_SAMPLE, 0, 0, 16'h1234);
    row_req(CMD_SAMPLE, 0, 0, 16'h7fff);
    // Shrink the channel count mid-pixel: the third sample closes it
    row_cfg(CFG_IN_CH, 5'd4);
    row_req(CMD_SAMPLE, 0, 0, 16'h0200);
    row_req(CMD_SAMPLE, 0, 0, 16'hff00);
    row_cfg(CFG_IN_CH, 5'd2);
    row_req(CMD_SAMPLE, 0, 0, 16'h0100);
    // Zero counts act as one
    row_cfg(CFG_IN_CH, 5'd0);
    row_cfg(CFG_OUT_CH, 5'd0);
    row_req(CMD_SAMPLE, 0, 0, 16'h4000);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
      end else begin
        send_req(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].want);
      end
    end

    // Reload both tables with random content before the random phases
    for (int oi = 0; oi < MAX_CH; oi++) begin
      for (int ii = 0; ii < MAX_CH; ii++) begin
        send_req(mk_req(CMD_WEIGHT, oi, ii, rand_value()), 1'b0, '0);
      end
      send_req(mk_req(CMD_BIAS, oi, 0, rand_value()), 1'b0, '0);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       begin n_in = 5'd1;  n_out = 5'd16; b_on = 1'b0; end
        1:       begin n_in = 5'd16; n_out = 5'd1;  b_on = 1'b1; end
        2:       begin n_in = 5'd31; n_out = 5'd31; b_on = 1'b1; end
        3:       begin n_in = 5'd2;  n_out = 5'd16; b_on = 1'b0; end
        4:       begin n_in = 5'd0;  n_out = 5'd0;  b_on = 1'b1; end
        default: begin
          n_in  = 5'($urandom_range(31));
          n_out = 5'($urandom_range(31));
          b_on  = 1'($urandom_range(1));
        end
      endcase
      write_reg(CFG_IN_CH, n_in);
      write_reg(CFG_OUT_CH, n_out);
      write_reg(CFG_BIAS_EN, 5'(b_on));

      // Phase 2 runs with no idling; phase 3 holds the drain side long
      // enough for the block to fill and stall its input.
      quiet <= (ph == 2);
      if (ph == 3) hold_go <= 1'b1;

      n = 0;
      while (n < PHASE_ITEMS) begin
        r = rand_req();
        send_req(r, 1'b0, '0);
        if (r.cmd != CMD_UNUSED) n++;
        // Pause the sender once until every owed result has drained
        if (ph == 4 && n == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          do @(negedge clk); while (pending_res.size() != 0);
        end
      end
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (pending_res.size() != 0);
    repeat (20) @(negedge clk);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
